FILE: hdl/ilp_pkg.sv
package ilp_pkg;

    localparam int DEF_WIDTH = 64;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 5;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_B  = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;

    localparam logic [DIGIT_W-1:0] DIGIT_BAD = 5'd31;
    localparam logic [DIGIT_W-1:0] HEX_TEN   = 5'd10;

    typedef enum logic [2:0] {
        PH_START,
        PH_MINUS,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_BIN,
        RX_OCT,
        RX_HEX
    } radix_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_MALFORMED,
        ST_OVERFLOW
    } status_t;

    typedef struct packed {
        phase_t  phase;
        radix_t  radix;
        logic    minus_seen;
        logic    has_digits;
        status_t err;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{
        phase:      PH_START,
        radix:      RX_DEC,
        minus_seen: 1'b0,
        has_digits: 1'b0,
        err:        ST_OK
    };

    function automatic logic [DIGIT_W-1:0] radix_base(input radix_t rx);
        logic [DIGIT_W-1:0] b;
        case (rx)
            RX_DEC:  b = 5'd10;
            RX_BIN:  b = 5'd2;
            RX_OCT:  b = 5'd8;
            RX_HEX:  b = 5'd16;
            default: b = 5'd10;
        endcase
        return b;
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        logic [CHAR_W-1:0]  t;
        t = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
            d = t[DIGIT_W-1:0];
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            t = c - CH_LC_A;
            d = t[DIGIT_W-1:0] + HEX_TEN;
        end else begin
            d = DIGIT_BAD;
        end
        return d;
    endfunction

endpackage

FILE: hdl/ilp_step.sv
module ilp_step #(
    parameter int WIDTH = ilp_pkg::DEF_WIDTH
) (
    input  ilp_pkg::ctrl_t                  cur,
    input  logic [WIDTH-1:0]                acc,
    input  logic [ilp_pkg::CHAR_W-1:0]      char_code,
    input  logic                            allow_sign,
    output ilp_pkg::ctrl_t                  nxt,
    output logic [WIDTH-1:0]                acc_next,
    output logic [ilp_pkg::STATUS_W-1:0]    status,
    output logic [WIDTH-1:0]                value
);
    import ilp_pkg::*;

    localparam int WIDE_W = WIDTH + 5;

    radix_t              radix_eff;
    logic [DIGIT_W-1:0]  digit;
    logic [DIGIT_W-1:0]  base;
    logic [WIDE_W-1:0]   acc_wide;
    logic [WIDE_W-1:0]   prod;
    logic [WIDE_W-1:0]   sum;
    logic                bad_digit;
    logic                ovf;
    status_t             st;

    // digit path: acc * base + d, exact overflow from the top bits
    always_comb begin
        radix_eff = (cur.phase == PH_START || cur.phase == PH_MINUS) ? RX_DEC : cur.radix;
        digit     = digit_of(char_code);
        base      = radix_base(radix_eff);
        acc_wide  = WIDE_W'(acc);
        case (radix_eff)
            RX_DEC:  prod = (acc_wide << 3) + (acc_wide << 1);
            RX_BIN:  prod = acc_wide << 1;
            RX_OCT:  prod = acc_wide << 3;
            RX_HEX:  prod = acc_wide << 4;
            default: prod = acc_wide;
        endcase
        sum       = prod + WIDE_W'(digit);
        bad_digit = (digit >= base);
        ovf       = |sum[WIDE_W-1:WIDTH];
    end

    always_comb begin
        nxt      = cur;
        acc_next = acc;
        if (cur.err == ST_OK) begin
            case (cur.phase)
                PH_START, PH_MINUS: begin
                    if (cur.phase == PH_START && char_code == CH_MINUS) begin
                        if (allow_sign) begin
                            nxt.minus_seen = 1'b1;
                            nxt.phase      = PH_MINUS;
                        end else begin
                            nxt.err = ST_MALFORMED;
                        end
                    end else if (char_code == CH_ZERO) begin
                        acc_next       = '0;
                        nxt.has_digits = 1'b1;
                        nxt.radix      = RX_OCT;
                        nxt.phase      = PH_ZERO;
                    end else begin
                        nxt.radix = RX_DEC;
                        if (bad_digit) begin
                            nxt.err = ST_MALFORMED;
                        end else if (ovf) begin
                            nxt.err = ST_OVERFLOW;
                        end else begin
                            acc_next       = sum[WIDTH-1:0];
                            nxt.has_digits = 1'b1;
                            nxt.phase      = PH_DIGITS;
                        end
                    end
                end
                PH_ZERO, PH_PREFIX, PH_DIGITS: begin
                    if (cur.phase == PH_ZERO &&
                        (char_code == CH_LC_B || char_code == CH_LC_X)) begin
                        nxt.radix      = (char_code == CH_LC_B) ? RX_BIN : RX_HEX;
                        nxt.has_digits = 1'b0;
                        acc_next       = '0;
                        nxt.phase      = PH_PREFIX;
                    end else if (bad_digit) begin
                        nxt.err = ST_MALFORMED;
                    end else if (ovf) begin
                        nxt.err = ST_OVERFLOW;
                    end else begin
                        acc_next       = sum[WIDTH-1:0];
                        nxt.has_digits = 1'b1;
                        nxt.phase      = PH_DIGITS;
                    end
                end
                default: nxt.err = ST_MALFORMED;
            endcase
        end
    end

    always_comb begin
        if (nxt.err != ST_OK) begin
            st = nxt.err;
        end else if (!nxt.has_digits) begin
            st = ST_MALFORMED;
        end else begin
            st = ST_OK;
        end
        status = st;
        if (st != ST_OK) begin
            value = '0;
        end else if (nxt.minus_seen) begin
            value = '0 - acc_next;
        end else begin
            value = acc_next;
        end
    end

endmodule

FILE: hdl/integer_literal_parser.sv
// Channel  | Ports                                  | Transfer
// ---------+----------------------------------------+-------------------------------
// input    | s_valid s_ready s_char_code s_last_char | one character per item
// result   | m_valid m_ready m_value m_status        | one item per literal, at last
// config   | cfg_we cfg_wr_data                      | allow_sign, written at once
//
// One character per cycle while s_ready is high: the state update is a
// shift-and-add with an exact overflow check from the top bits, done in the
// cycle the character is taken. The result sits in an output register;
// s_ready drops only while that register is full and m_ready is low.
// Synchronous active-low reset clears the literal state and sets allow_sign.
module integer_literal_parser #(
    parameter int WIDTH = ilp_pkg::DEF_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ilp_pkg::CHAR_W-1:0]      s_char_code,
    input  logic                            s_last_char,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ilp_pkg::VALUE_W-1:0]     m_value,
    output logic [ilp_pkg::STATUS_W-1:0]    m_status
);
    import ilp_pkg::*;

    ctrl_t                 ctrl_reg, ctrl_next, ctrl_step;
    logic [WIDTH-1:0]      acc_reg, acc_next, acc_step;
    logic                  allow_sign_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]    m_value_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [STATUS_W-1:0]   step_status;
    logic [WIDTH-1:0]      step_value;
    logic                  s_fire;

    ilp_step #(.WIDTH(WIDTH)) u_step (
        .cur        (ctrl_reg),
        .acc        (acc_reg),
        .char_code  (s_char_code),
        .allow_sign (allow_sign_reg),
        .nxt        (ctrl_step),
        .acc_next   (acc_step),
        .status     (step_status),
        .value      (step_value)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        ctrl_next    = ctrl_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (s_fire) begin
            if (s_last_char) begin
                ctrl_next    = CTRL_RESET;
                acc_next     = '0;
                m_valid_next = 1'b1;
            end else begin
                ctrl_next = ctrl_step;
                acc_next  = acc_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg       <= CTRL_RESET;
            acc_reg        <= '0;
            allow_sign_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            ctrl_reg    <= ctrl_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                allow_sign_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_last_char) begin
            m_value_reg  <= VALUE_W'(step_value);
            m_status_reg <= step_status;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_last_char |=> m_valid)
        else $error("last character did not produce a result");

    a_last_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_last_char |=> ctrl_reg == CTRL_RESET && acc_reg == '0)
        else $error("literal state not cleared after result");

    a_error_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_value == '0)
        else $error("nonzero value with error status");

    a_start_acc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.phase == PH_START || ctrl_reg.phase == PH_MINUS |-> acc_reg == '0)
        else $error("accumulator nonzero before first digit");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.err != ST_OK && !(s_fire && s_last_char) |=> ctrl_reg.err == $past(ctrl_reg.err))
        else $error("first error overwritten");

endmodule

FILE: dv/tb_integer_literal_parser.sv
`timescale 1ns / 1ps

module tb_integer_literal_parser;
    import ilp_pkg::*;

    localparam int          LIT_W         = 64;
    localparam logic [63:0] LIT_MASK      = {64{1'b1}} >> (64 - LIT_W);
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          PHASE_CHARS   = 340;
    localparam longint      TIMEOUT_NS    = 2_000_000;
    localparam int unsigned NO_DIGIT      = 99;

    typedef struct {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } lit_result_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic                   cfg_wr_data = 1'b0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic [CHAR_W-1:0]      s_char_code = '0;
    logic                   s_last_char = 1'b0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic [VALUE_W-1:0]     m_value;
    logic [STATUS_W-1:0]    m_status;

    // predictor state
    logic        allow_minus;
    phase_t      lit_phase;
    radix_t      lit_radix;
    logic [63:0] lit_acc;
    logic        lit_minus;
    logic        lit_has_digits;
    status_t     lit_err;

    lit_result_t       expected_lits[$];
    logic [CHAR_W-1:0] lit_buf[$];

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int          rx_hold      = 0;
    int          chars_sent   = 0;
    int          lits_sent    = 0;
    int          results_seen = 0;
    int          fail_count   = 0;

    integer_literal_parser #(.WIDTH(LIT_W)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last_char (s_last_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_status    (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic void clear_literal();
        lit_phase      = PH_START;
        lit_radix      = RX_DEC;
        lit_acc        = '0;
        lit_minus      = 1'b0;
        lit_has_digits = 1'b0;
        lit_err        = ST_OK;
    endfunction

    function automatic int unsigned char_digit(logic [CHAR_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
        return NO_DIGIT;
    endfunction

    function automatic void add_digit(logic [CHAR_W-1:0] c);
        logic [63:0] base;
        logic [63:0] d;
        case (lit_radix)
            RX_BIN:  base = 64'd2;
            RX_OCT:  base = 64'd8;
            RX_HEX:  base = 64'd16;
            default: base = 64'd10;
        endcase
        d = 64'(char_digit(c));
        if (d >= base) begin
            lit_err = ST_MALFORMED;
        end else if (lit_acc > (LIT_MASK - d) / base) begin
            lit_err = ST_OVERFLOW;
        end else begin
            lit_acc        = lit_acc * base + d;
            lit_has_digits = 1'b1;
            lit_phase      = PH_DIGITS;
        end
    endfunction

    function automatic void lead_digit(logic [CHAR_W-1:0] c);
        if (c == CH_ZERO) begin
            lit_acc        = '0;
            lit_has_digits = 1'b1;
            lit_radix      = RX_OCT;
            lit_phase      = PH_ZERO;
        end else begin
            lit_radix = RX_DEC;
            add_digit(c);
        end
    endfunction

    function automatic void predict_char(logic [CHAR_W-1:0] c, logic last);
        lit_result_t r;
        if (lit_err == ST_OK) begin
            case (lit_phase)
                PH_START: begin
                    if (c == CH_MINUS) begin
                        if (allow_minus) begin
                            lit_minus = 1'b1;
                            lit_phase = PH_MINUS;
                        end else begin
                            lit_err = ST_MALFORMED;
                        end
                    end else begin
                        lead_digit(c);
                    end
                end
                PH_MINUS: lead_digit(c);
                PH_ZERO: begin
                    if (c == CH_LC_B || c == CH_LC_X) begin
                        lit_radix      = (c == CH_LC_B) ? RX_BIN : RX_HEX;
                        lit_has_digits = 1'b0;
                        lit_acc        = '0;
                        lit_phase      = PH_PREFIX;
                    end else begin
                        add_digit(c);
                    end
                end
                PH_PREFIX, PH_DIGITS: add_digit(c);
                default: lit_err = ST_MALFORMED;
            endcase
        end
        if (last) begin
            r.value = '0;
            if (lit_err != ST_OK) r.status = lit_err;
            else if (!lit_has_digits) r.status = ST_MALFORMED;
            else r.status = ST_OK;
            if (r.status == ST_OK)
                r.value = (lit_minus ? (64'd0 - lit_acc) : lit_acc) & LIT_MASK;
            expected_lits.push_back(r);
            lits_sent++;
            clear_literal();
        end
    endfunction

    // ---------------- result side ----------------

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        lit_result_t r;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_lits.size() == 0) begin
                $error("unexpected result: value=%h status=%0d", m_value, m_status);
                fail_count++;
            end else begin
                r = expected_lits.pop_front();
                if (m_value !== r.value) begin
                    $error("value: expected %h, actual %h", r.value, m_value);
                    fail_count++;
                end
                if (m_status !== r.status) begin
                    $error("status: expected %0d, actual %0d", r.status, m_status);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- input side ----------------

    task automatic send_item(logic [CHAR_W-1:0] c, logic last);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_last_char <= last;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
        predict_char(c, last);
    endtask

    task automatic send_buf();
        for (int i = 0; i < lit_buf.size(); i++)
            send_item(lit_buf[i], i == lit_buf.size() - 1);
    endtask

    task automatic send_text(string s);
        lit_buf.delete();
        for (int i = 0; i < s.len(); i++) lit_buf.push_back(s[i]);
        send_buf();
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_lits.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_allow_sign(logic v);
        settle();
        cfg_we      <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        allow_minus = v;
    endtask

    function automatic logic [CHAR_W-1:0] digit_char(int unsigned d);
        return (d < 10) ? CH_ZERO + 8'(d) : CH_LC_A + 8'(d - 10);
    endfunction

    // mostly well-formed literals, some corrupted, some pure noise
    task automatic make_literal();
        int unsigned roll;
        int unsigned base;
        int unsigned maxd;
        int unsigned ndig;
        int unsigned pos;
        radix_t      rx;
        lit_buf.delete();
        roll = $urandom_range(99);
        if (roll < 5) begin
            repeat ($urandom_range(1, 4)) lit_buf.push_back(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(99) < 35) lit_buf.push_back(CH_MINUS);
        rx = radix_t'($urandom_range(3));
        case (rx)
            RX_BIN: begin
                lit_buf.push_back(CH_ZERO); lit_buf.push_back(CH_LC_B);
                base = 2; maxd = 64;
            end
            RX_HEX: begin
                lit_buf.push_back(CH_ZERO); lit_buf.push_back(CH_LC_X);
                base = 16; maxd = 16;
            end
            RX_OCT: begin
                lit_buf.push_back(CH_ZERO);
                base = 8; maxd = 22;
            end
            default: begin
                base = 10; maxd = 20;
            end
        endcase
        if ($urandom_range(99) < 10) ndig = $urandom_range(maxd - 1, maxd + 1);
        else if (rx == RX_OCT) ndig = $urandom_range(0, 4);
        else ndig = $urandom_range(1, 5);
        for (int i = 0; i < ndig; i++) begin
            if (rx == RX_DEC && i == 0) lit_buf.push_back(digit_char($urandom_range(1, 9)));
            else lit_buf.push_back(digit_char($urandom_range(base - 1)));
        end
        if (lit_buf.size() == 0) lit_buf.push_back(CH_MINUS);
        if (roll < 18) begin
            pos = $urandom_range(lit_buf.size() - 1);
            lit_buf[pos] = 8'($urandom_range(255));
        end else if (roll < 24) begin
            pos = $urandom_range(1, lit_buf.size());
            lit_buf.insert(pos, CH_MINUS);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        send_text("0");
        send_text("-0");
        send_text("9");
        send_text("-");
        send_text("0b");
        send_text("0x");
        send_text("-0x");
        send_text("08");
        send_text("0X");
        send_text("0xA");
        send_text("1-2");
        send_text("0b1");
        send_text("-0xf");
        send_text("0xffffffffffffffff");
        send_text("0x10000000000000000");
    endtask

    task automatic test_sign_disabled();
        set_allow_sign(1'b0);
        send_text("-5");
        send_text("7");
        set_allow_sign(1'b1);
        send_text("-5");
    endtask

    task automatic test_random(int unsigned tx, int unsigned rx, logic allow, int n);
        int stop;
        set_allow_sign(allow);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        stop = chars_sent + n;
        while (chars_sent < stop) begin
            make_literal();
            send_buf();
        end
    endtask

    // receiver holds off while the sender keeps pushing literals
    task automatic test_backpressure();
        set_allow_sign(1'b1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = HOLD_CYCLES;
        repeat (30) begin
            make_literal();
            send_buf();
        end
    endtask

    initial begin
        allow_minus = 1'b1;
        clear_literal();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_sign_disabled();
        test_random(0, 0, 1'b1, PHASE_CHARS);
        test_random(72, 0, 1'b0, PHASE_CHARS);
        test_random(0, 72, 1'b1, PHASE_CHARS);
        test_random(29, 29, 1'b0, PHASE_CHARS);
        test_backpressure();
        settle();

        $display("ran %0d chars as %0d literals, %0d results checked", chars_sent, lits_sent,
                 results_seen);
        $display("covered all radixes, sign on/off, bad digits, overflow, stalls and hold-off");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/ilp_pkg.sv
hdl/ilp_step.sv
hdl/integer_literal_parser.sv
dv/tb_integer_literal_parser.sv
